// File: hw/rtl/afs16_pkg.sv
// ----------------------------------------------------------------------------
// afs16_pkg: shared types and constants
// Register indexes, format codes and the per-sample conversion functions.
// ----------------------------------------------------------------------------
package afs16_pkg;

	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_VAL_W = 4;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned SMP_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BYTES  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 4'd1;

	localparam logic [CFG_VAL_W-1:0] FMT_U8  = 4'd1;
	localparam logic [CFG_VAL_W-1:0] FMT_S16 = 4'd2;
	localparam logic [CFG_VAL_W-1:0] FMT_F32 = 4'd4;
	localparam logic [CFG_VAL_W-1:0] CH_MONO   = 4'd1;
	localparam logic [CFG_VAL_W-1:0] CH_STEREO = 4'd2;

	localparam logic [CFG_VAL_W-1:0] SAMPLE_BYTES_RST  = FMT_S16;
	localparam logic [CFG_VAL_W-1:0] CHANNEL_COUNT_RST = CH_STEREO;

	// conversion mode decoded from the two registers
	typedef enum logic [1:0] {
		MODE_SILENT = 2'd0,
		MODE_U8     = 2'd1,
		MODE_S16    = 2'd2,
		MODE_F32    = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic  mono;
	} conv_ctl_t;

	// unsigned 8-bit to s16: (u - 128) << 8 is just the msb flipped
	function automatic logic [SMP_W-1:0] conv_u8(input logic [WORD_W-1:0] w);
		conv_u8 = {~w[7], w[6:0], 8'h00};
	endfunction

	// float32 to s16: clamp to +-1, times 32767 rounded to nearest even in
	// single precision, then truncate toward zero
	function automatic logic [SMP_W-1:0] conv_f32(input logic [WORD_W-1:0] w);
		logic [7:0]  e;
		logic [23:0] m;
		logic [39:0] prod;
		logic [39:0] shifted;
		logic [14:0] ipart;
		logic [5:0]  sh;
		logic        lsb;
		logic        rbit;
		logic        stick;
		logic [25:0] top;
		logic [15:0] mag;
		e     = w[30:23];
		m     = {1'b1, w[22:0]};
		prod  = '0;
		shifted = '0;
		ipart = '0;
		sh    = '0;
		lsb   = 1'b0;
		rbit  = 1'b0;
		stick = 1'b0;
		top   = '0;
		mag   = '0;
		if (e == 8'hFF && w[22:0] != 23'd0) begin
			mag = '0;
		end else if (e >= 8'd127) begin
			mag = 16'd32767;
		end else if (e < 8'd103) begin
			// below 2^-24 the product is under 1/512: truncates to zero
			mag = '0;
		end else begin
			// product m*32767 is 39 bits; value = prod * 2^(e-127-23)
			prod = 40'(m) * 40'd32767;
			// float keeps 24 significant bits; msb at bit 38 or 37
			if (prod[38]) begin
				top   = prod[38:13];
				stick = |prod[12:0];
				lsb   = top[2];
				rbit  = top[1];
				stick = stick | top[0];
				prod  = {1'b0, prod[38:15], 15'd0};
				if (rbit && (stick || lsb))
					prod = prod + 40'h0000008000;
			end else begin
				top   = prod[37:12];
				stick = |prod[11:0];
				lsb   = top[2];
				rbit  = top[1];
				stick = stick | top[0];
				prod  = {2'b0, prod[37:14], 14'd0};
				if (rbit && (stick || lsb))
					prod = prod + 40'h0000004000;
			end
			// integer part: prod >> (150 - e), e in 103..126 -> 24..47
			sh = 6'(8'd150 - e);
			shifted = prod >> sh;
			ipart = shifted[14:0];
			mag = {1'b0, ipart};
		end
		conv_f32 = w[31] ? 16'(-mag) : mag;
	endfunction

endpackage

// File: hw/rtl/afs16_ctl.sv
// ----------------------------------------------------------------------------
// afs16_ctl: configuration registers
// Holds sample size and channel count and decodes the conversion mode.
// ----------------------------------------------------------------------------
module afs16_ctl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [afs16_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [afs16_pkg::CFG_VAL_W-1:0]   cfg_data,
	output afs16_pkg::conv_ctl_t              ctl
);
	import afs16_pkg::*;

	logic [CFG_VAL_W-1:0] sample_bytes_q;
	logic [CFG_VAL_W-1:0] channel_count_q;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bytes_q  <= SAMPLE_BYTES_RST;
			channel_count_q <= CHANNEL_COUNT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SAMPLE_BYTES)
				sample_bytes_q <= cfg_data;
			else if (cfg_index == REG_CHANNEL_COUNT)
				channel_count_q <= cfg_data;
		end
	end

	// mode decode; 8-bit treats any count but mono as stereo
	always_comb begin
		ctl.mono = (channel_count_q == CH_MONO);
		ctl.mode = MODE_SILENT;
		if (sample_bytes_q == FMT_U8)
			ctl.mode = MODE_U8;
		else if (channel_count_q == CH_MONO || channel_count_q == CH_STEREO) begin
			if (sample_bytes_q == FMT_S16)
				ctl.mode = MODE_S16;
			else if (sample_bytes_q == FMT_F32)
				ctl.mode = MODE_F32;
		end
	end

endmodule

// File: hw/rtl/audio_frame_to_s16_stereo_unit.sv
// ----------------------------------------------------------------------------
// audio_frame_to_s16_stereo_unit: PCM frame to s16 stereo converter
// Converts u8, s16 or float32 mono/stereo frames to signed 16-bit stereo.
// ----------------------------------------------------------------------------
// channel | signals                                   | direction
// in      | in_valid/in_ready, left/right_word, last  | input beats
// out     | out_valid/out_ready, left/right_sample    | result beats
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | register writes
//
// One beat per cycle while the output is not stalled; a beat passes the
// input register, then the conversion logic, then the result register.
// Reset clears the valid flags and loads s16 stereo.
// A stall on the output holds the result register and, when the input
// register is also full, stops the input side.
// ----------------------------------------------------------------------------
module audio_frame_to_s16_stereo_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [afs16_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [afs16_pkg::CFG_VAL_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [afs16_pkg::WORD_W-1:0]    left_word,
	input  logic [afs16_pkg::WORD_W-1:0]    right_word,
	input  logic                            frame_last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [afs16_pkg::SMP_W-1:0] left_sample,
	output logic signed [afs16_pkg::SMP_W-1:0] right_sample,
	output logic                            out_last
);
	import afs16_pkg::*;

	conv_ctl_t         ctl;
	logic              vld_s1;
	logic [WORD_W-1:0] lw_s1;
	logic [WORD_W-1:0] rw_s1;
	logic              last_s1;
	logic              vld_s2;
	logic [SMP_W-1:0]  l_s2;
	logic [SMP_W-1:0]  r_s2;
	logic              last_s2;
	logic [SMP_W-1:0]  l_c;
	logic [SMP_W-1:0]  r_c;
	logic              adv_s2;

	afs16_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl)
	);

	assign adv_s2   = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_ready)
			vld_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			lw_s1   <= left_word;
			rw_s1   <= right_word;
			last_s1 <= frame_last;
		end
	end

	// conversion
	always_comb begin
		l_c = '0;
		r_c = '0;
		unique case (ctl.mode)
			MODE_U8: begin
				l_c = conv_u8(lw_s1);
				r_c = ctl.mono ? l_c : conv_u8(rw_s1);
			end
			MODE_S16: begin
				l_c = lw_s1[SMP_W-1:0];
				r_c = ctl.mono ? l_c : rw_s1[SMP_W-1:0];
			end
			MODE_F32: begin
				l_c = conv_f32(lw_s1);
				r_c = ctl.mono ? l_c : conv_f32(rw_s1);
			end
			MODE_SILENT: begin
				l_c = '0;
				r_c = '0;
			end
			default: begin
				l_c = '0;
				r_c = '0;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (adv_s2)
			vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			l_s2    <= l_c;
			r_s2    <= r_c;
			last_s2 <= last_s1;
		end
	end

	assign out_valid    = vld_s2;
	assign left_sample  = l_s2;
	assign right_sample = r_s2;
	assign out_last     = last_s2;

endmodule
